// File: sv/arpl_pkg.sv
// Shared types, constants and decode helpers for the audio level meter.
`timescale 1ns / 1ps

package arpl_pkg;

    // Sample count limit per buffer
    localparam int MAX_SAMPLES_LOG2 = 16;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = 63;
    localparam int COUNT_W = 17;
    localparam int FMT_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1 << MAX_SAMPLES_LOG2);

    // Sample format codes
    localparam logic [FMT_W-1:0] FMT_FLOAT32 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_PCM16   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_PCM24   = 2'd2;
    localparam logic [FMT_W-1:0] FMT_UNSUP   = 2'd3;

    // Q1.23 saturation magnitudes
    localparam logic [MAG_W-1:0] MAG_POS_SAT = 24'h7F_FFFF;
    localparam logic [MAG_W-1:0] MAG_NEG_SAT = 24'h80_0000;

    // Float exponent points
    localparam logic [7:0] EXP_ONE = 8'd127;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Classified sample handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0] mag;   // magnitude in Q1.23
        logic             sat;   // float saturated
        logic             last;  // closes the buffer
        logic             skip;  // unsupported format, not accumulated
    } arpl_sample_t;

    // Magnitude of a 24-bit two's complement value
    function automatic logic [MAG_W-1:0] abs_q23(input logic [MAG_W-1:0] v);
        abs_q23 = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
    endfunction

endpackage

// File: sv/arpl_front.sv
// Front end: config register, input handshake and sample decode to Q1.23 magnitude.
`timescale 1ns / 1ps

module arpl_front
    import arpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [WORD_W-1:0]  s_tdata,
    input  logic               s_tlast,
    // to queue
    output logic               push,
    output arpl_sample_t       push_item,
    input  logic               push_ready
);

    logic [FMT_W-1:0] fmt_reg;
    logic [7:0]       exp_f;
    logic [6:0]       shift_f;
    logic [MAG_W-1:0] full_f;
    logic [MAG_W-1:0] mag;
    logic             sat;
    logic             skip;

    // Format register; single register decodes every address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_PCM16;
        end
        else if (psel && penable && pwrite)
        begin
            fmt_reg <= pwdata[FMT_W-1:0];
        end
    end

    assign prdata = {{(32 - FMT_W){1'b0}}, fmt_reg};

    // Sample decode
    always_comb
    begin
        exp_f   = s_tdata[30:23];
        full_f  = {1'b1, s_tdata[22:0]};
        shift_f = 7'(EXP_ONE - exp_f);
        mag     = '0;
        sat     = 1'b0;
        skip    = 1'b0;
        case (fmt_reg)
            FMT_FLOAT32:
            begin
                if (exp_f >= EXP_ONE)
                begin
                    sat = 1'b1;
                    mag = s_tdata[31] ? MAG_NEG_SAT : MAG_POS_SAT;
                end
                else if (exp_f == 8'd0)
                begin
                    mag = '0;
                end
                else if (shift_f >= 7'(MAG_W))
                begin
                    mag = '0;
                end
                else
                begin
                    mag = full_f >> shift_f;
                end
            end
            FMT_PCM16:
            begin
                mag = abs_q23({s_tdata[15:0], 8'h00});
            end
            FMT_PCM24:
            begin
                mag = abs_q23(s_tdata[31:8]);
            end
            default:
            begin
                skip = 1'b1;
            end
        endcase
    end

    assign s_tready       = push_ready;
    assign push           = s_tvalid && push_ready;
    assign push_item.mag  = mag;
    assign push_item.sat  = sat;
    assign push_item.last = s_tlast;
    assign push_item.skip = skip;

endmodule

// File: sv/arpl_queue.sv
// Short FIFO of classified samples between front and back.
`timescale 1ns / 1ps

module arpl_queue
    import arpl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  arpl_sample_t push_item,
    output logic         push_ready,
    input  logic         pop,
    output arpl_sample_t pop_item,
    output logic         pop_valid
);

    arpl_sample_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW:0]      fill_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (fill_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (QUEUE_AW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (QUEUE_AW + 1)'(1);
            end
        end
    end

    // Fill level stays within depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    // A full queue takes no beat
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!push_ready && !do_pop) |=> (fill_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH)))
        else $error("queue fill changed while full and not drained");

    // An empty queue offers nothing
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> !pop_valid)
        else $error("queue valid while empty");

endmodule

// File: sv/arpl_back.sv
// Back end: square stage, accumulate stage and registered result beat.
`timescale 1ns / 1ps

module arpl_back
    import arpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // from queue
    input  logic                pop_valid,
    input  arpl_sample_t        pop_item,
    output logic                pop,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [103:0]        m_tdata,
    output logic                m_tuser
);

    // square stage
    logic                a_valid_reg;
    arpl_sample_t        a_item_reg;
    logic [SQ_W-1:0]     a_sq_reg;
    logic                a_load;
    logic                a_fire;

    // accumulators
    logic [SUM_W-1:0]    acc_sum_reg;
    logic [SUM_W-1:0]    acc_sum_next;
    logic [MAG_W-1:0]    acc_peak_reg;
    logic [MAG_W-1:0]    acc_peak_next;
    logic [COUNT_W-1:0]  acc_count_reg;
    logic [COUNT_W-1:0]  acc_count_next;
    logic                acc_flag_reg;
    logic                acc_flag_next;
    logic                at_limit;

    // result register
    logic                out_valid_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic [MAG_W-1:0]    out_peak_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_flag_reg;
    logic                out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign a_fire   = a_valid_reg && (!a_item_reg.last || out_free);
    assign a_load   = !a_valid_reg || a_fire;
    assign pop      = a_load && pop_valid;

    // Square stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_item_reg <= pop_item;
            a_sq_reg   <= pop_item.mag * pop_item.mag;
        end
    end

    // Accumulate: a sample at the count limit only raises the flag
    always_comb
    begin
        at_limit       = (acc_count_reg >= COUNT_LIMIT);
        acc_sum_next   = acc_sum_reg;
        acc_peak_next  = acc_peak_reg;
        acc_count_next = acc_count_reg;
        acc_flag_next  = acc_flag_reg;
        if (!a_item_reg.skip)
        begin
            acc_flag_next = acc_flag_reg || a_item_reg.sat || at_limit;
            if (!at_limit)
            begin
                acc_sum_next   = acc_sum_reg + SUM_W'(a_sq_reg);
                acc_peak_next  = (a_item_reg.mag > acc_peak_reg) ? a_item_reg.mag
                                                                  : acc_peak_reg;
                acc_count_next = acc_count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sum_reg   <= '0;
            acc_peak_reg  <= '0;
            acc_count_reg <= '0;
            acc_flag_reg  <= 1'b0;
        end
        else if (a_fire)
        begin
            if (a_item_reg.last)
            begin
                acc_sum_reg   <= '0;
                acc_peak_reg  <= '0;
                acc_count_reg <= '0;
                acc_flag_reg  <= 1'b0;
            end
            else
            begin
                acc_sum_reg   <= acc_sum_next;
                acc_peak_reg  <= acc_peak_next;
                acc_count_reg <= acc_count_next;
                acc_flag_reg  <= acc_flag_next;
            end
        end
    end

    // Result beat; unsupported format closes with all-zero totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_fire && a_item_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire && a_item_reg.last)
        begin
            if (a_item_reg.skip)
            begin
                out_sum_reg   <= '0;
                out_peak_reg  <= '0;
                out_count_reg <= '0;
                out_flag_reg  <= 1'b0;
            end
            else
            begin
                out_sum_reg   <= acc_sum_next;
                out_peak_reg  <= acc_peak_next;
                out_count_reg <= acc_count_next;
                out_flag_reg  <= acc_flag_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_peak_reg, out_sum_reg};
    assign m_tuser  = out_flag_reg;

    // Totals clear after a buffer closes
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && a_item_reg.last) |=> (acc_count_reg == '0 && acc_sum_reg == '0))
        else $error("accumulators not cleared after last sample");

    // Count never passes the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_count_reg <= COUNT_LIMIT)
        else $error("sample count above limit");

    // No samples counted means nothing summed
    a_empty_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_count_reg == '0) |-> (acc_sum_reg == '0 && acc_peak_reg == '0))
        else $error("totals nonzero with zero count");

    // A closing sample never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && a_item_reg.last) |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before taken");

endmodule

// File: sv/audio_rms_peak_level_meter.sv
// A closing sample passes the queue, the square stage and the result register.
// Throughput: one sample per cycle unless stalled; 24x24 square, 63-bit accumulate.
// A 4-entry queue decouples decode from accumulate, so each side stalls on its own.
// Reset (rst_n, async low): totals and queue cleared, sample format set to pcm16.
// Result beats that wait on m_tready do not block later non-closing samples.
`timescale 1ns / 1ps

module audio_rms_peak_level_meter
    import arpl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // sample stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,    // [31:0] sample_word
    input  logic          s_tlast,    // last_in_buffer
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,    // [62:0] sum_squares, [86:63] peak_abs,
                                      // [103:87] sample_count
    output logic          m_tuser     // range_flag
);

    logic         push;
    arpl_sample_t push_item;
    logic         push_ready;
    logic         pop;
    arpl_sample_t pop_item;
    logic         pop_valid;
    logic [31:0]  fmt_rdata;

    assign pready = 1'b1;
    // one register: every address maps to it
    assign prdata = (paddr == 2'd0) ? fmt_rdata : fmt_rdata;

    arpl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pwdata     (pwdata),
        .prdata     (fmt_rdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    arpl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid)
    );

    arpl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: sim/audio_rms_peak_level_meter_tb.sv
// Self-checking testbench for the audio level meter: sample stream in, buffer totals out.
`timescale 1ns / 1ps

module audio_rms_peak_level_meter_tb;
    import arpl_pkg::*;

    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam int Q23_MAX = 8388607;
    localparam int Q23_MIN = -8388608;
    localparam int ITEMS_PER_PHASE = 150;

    // One set of buffer totals
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [MAG_W-1:0]   peak;
        logic [COUNT_W-1:0] count;
        logic               flag;
    } meter_t;

    // One directed stimulus row
    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [31:0]      word;
        logic             last;
        logic             typed;
        meter_t           res;
    } stim_row_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [1:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_tvalid;
    logic          s_tready;
    logic [31:0]   s_tdata;    // [31:0] sample_word
    logic          s_tlast;    // last_in_buffer
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [103:0]  m_tdata;    // [62:0] sum_squares, [86:63] peak_abs, [103:87] sample_count
    logic          m_tuser;    // range_flag

    // Predictor state
    logic [FMT_W-1:0]   fmt_q;
    logic [SUM_W-1:0]   acc_sum;
    logic [MAG_W-1:0]   acc_peak;
    logic [COUNT_W-1:0] acc_count;
    logic               acc_flag;

    meter_t    meter_reports_q[$];
    stim_row_t stim_rows[$];
    meter_t    got;
    meter_t    want;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_count      = 0;
    int beats_sent     = 0;
    int reports_seen   = 0;

    audio_rms_peak_level_meter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Result-side backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Decode a raw word to signed Q1.23; sat marks float saturation
    function automatic int decode_q23(input logic [FMT_W-1:0] fmt, input logic [31:0] w,
                                      output logic sat);
        logic [7:0]  ex;
        logic [23:0] full;
        int          sh;
        int          mag;
        sat = 1'b0;
        ex  = w[30:23];
        if (fmt == FMT_FLOAT32)
        begin
            if (ex >= EXP_ONE)
            begin
                sat = 1'b1;
                return w[31] ? Q23_MIN : Q23_MAX;
            end
            if (ex == 8'd0)
                return 0;
            sh   = 127 - int'(ex);
            full = {1'b1, w[22:0]};
            mag  = (sh >= 24) ? 0 : int'(full >> sh);
            return w[31] ? -mag : mag;
        end
        else if (fmt == FMT_PCM16)
            return int'($signed(w[15:0])) * 256;
        else
            return int'($signed(w)) >>> 8;
    endfunction

    // Fold one accepted sample into the running totals
    task automatic meter_accumulate(input logic [31:0] word, input logic last,
                                    output logic has_res, output meter_t res);
        int          v;
        logic        sat;
        logic [MAG_W-1:0] mag;
        has_res = 1'b0;
        res     = '0;
        if (fmt_q != FMT_UNSUP)
        begin
            v = decode_q23(fmt_q, word, sat);
            if (sat)
                acc_flag = 1'b1;
            if (acc_count >= COUNT_LIMIT)
                acc_flag = 1'b1;
            else
            begin
                mag       = MAG_W'((v < 0) ? -v : v);
                acc_sum   = acc_sum + SUM_W'(mag) * SUM_W'(mag);
                if (mag > acc_peak)
                    acc_peak = mag;
                acc_count = acc_count + 1'b1;
            end
        end
        if (last)
        begin
            has_res = 1'b1;
            if (fmt_q != FMT_UNSUP)
            begin
                res.sum   = acc_sum;
                res.peak  = acc_peak;
                res.count = acc_count;
                res.flag  = acc_flag;
            end
            acc_sum   = '0;
            acc_peak  = '0;
            acc_count = '0;
            acc_flag  = 1'b0;
        end
    endtask

    // Send one sample beat; typed overrides the predicted totals
    task automatic push_sample(input logic [31:0] word, input logic last,
                               input logic typed, input meter_t typed_res);
        logic   has_res;
        meter_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
        meter_accumulate(word, last, has_res, res);
        if (has_res)
            meter_reports_q.push_back(typed ? typed_res : res);
    endtask

    // Register write once the block has drained
    task automatic set_sample_format(input logic [FMT_W-1:0] fmt);
        s_tvalid <= 1'b0;
        while (meter_reports_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SAMPLE_FORMAT;
        pwdata  <= {30'd0, fmt};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fmt_q = fmt;
    endtask

    task automatic add_row(input logic [FMT_W-1:0] fmt, input logic [31:0] word,
                           input logic last, input logic typed,
                           input logic [SUM_W-1:0] sum, input logic [MAG_W-1:0] peak,
                           input logic [COUNT_W-1:0] count, input logic flag);
        stim_row_t r;
        r.fmt       = fmt;
        r.word      = word;
        r.last      = last;
        r.typed     = typed;
        r.res.sum   = sum;
        r.res.peak  = peak;
        r.res.count = count;
        r.res.flag  = flag;
        stim_rows.push_back(r);
    endtask

    function automatic logic [FMT_W-1:0] pick_format();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return FMT_FLOAT32;
        else if (r < 60)
            return FMT_PCM16;
        else if (r < 90)
            return FMT_PCM24;
        else
            return FMT_UNSUP;
    endfunction

    // Floats biased toward the decodable range, with specials mixed in
    function automatic logic [31:0] rand_float();
        logic [7:0] e;
        int         r;
        r = $urandom_range(99);
        if (r < 45)
            e = 8'($urandom_range(126, 100));
        else if (r < 60)
            e = 8'($urandom_range(99, 1));
        else if (r < 72)
            e = 8'($urandom_range(254, 127));
        else if (r < 80)
            e = 8'hFF;
        else if (r < 88)
            e = 8'h00;
        else
            e = 8'($urandom);
        return {1'($urandom_range(1)), e, 23'($urandom)};
    endfunction

    function automatic logic [31:0] rand_pcm();
        if ($urandom_range(99) >= 15)
            return $urandom;
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_8000;
            3:       return 32'h0000_7FFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Random buffers of mostly short length, formats switched between and inside
    task automatic run_random_phase(input int src_pct, input int sink_pct, input int n_items);
        int   counted;
        int   len;
        logic [31:0] word;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        counted = 0;
        while (counted < n_items)
        begin
            if ($urandom_range(3) == 0)
                set_sample_format(pick_format());
            len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7);
            for (int i = 0; i < len; i++)
            begin
                if (i > 0 && $urandom_range(49) == 0)
                    set_sample_format(pick_format());
                word = (fmt_q == FMT_FLOAT32) ? rand_float() : rand_pcm();
                if (fmt_q != FMT_UNSUP)
                    counted++;
                push_sample(word, i == len - 1, 1'b0, '0);
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sum   = m_tdata[62:0];
            got.peak  = m_tdata[86:63];
            got.count = m_tdata[103:87];
            got.flag  = m_tuser;
            if (meter_reports_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR %0t: result beat with none pending: %0s",
                             $realtime, $sformatf("sum=%0d peak=%0d cnt=%0d flag=%0b",
                             got.sum, got.peak, got.count, got.flag));
            end
            else
            begin
                want = meter_reports_q.pop_front();
                reports_seen++;
                if (got.sum !== want.sum || got.peak !== want.peak ||
                    got.count !== want.count || got.flag !== want.flag)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("ERROR %0t: totals differ", $realtime);
                        $display("  sum   exp %0d got %0d", want.sum, got.sum);
                        $display("  peak  exp %0d got %0d", want.peak, got.peak);
                        $display("  count exp %0d got %0d", want.count, got.count);
                        $display("  flag  exp %0b got %0b", want.flag, got.flag);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        fmt_q     = FMT_PCM16;
        acc_sum   = '0;
        acc_peak  = '0;
        acc_count = '0;
        acc_flag  = 1'b0;

        // pcm16 extremes, starting from the reset format
        add_row(FMT_PCM16, 32'h0000_7FFF, 1'b1, 1'b1,
                63'((64'd1 << 46) - (64'd1 << 32) + (64'd1 << 16)), 24'h7F_FF00, 17'd1, 1'b0);
        add_row(FMT_PCM16, 32'h1234_8000, 1'b1, 1'b1, 63'(64'd1 << 46), 24'h80_0000, 17'd1,
                1'b0);
        add_row(FMT_PCM16, 32'hFFFF_0000, 1'b1, 1'b1, '0, '0, 17'd1, 1'b0);
        // float: one, infinity, NaN, signed zero, denormal, truncation
        add_row(FMT_FLOAT32, 32'h3F80_0000, 1'b1, 1'b1,
                63'((64'd1 << 46) - (64'd1 << 24) + 64'd1), 24'h7F_FFFF, 17'd1, 1'b1);
        add_row(FMT_FLOAT32, 32'hFF80_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_FLOAT32, 32'h7FC0_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_FLOAT32, 32'h8000_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_FLOAT32, 32'h0000_0001, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_FLOAT32, 32'h3F00_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_FLOAT32, 32'hBF7F_FFFF, 1'b1, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_FLOAT32, 32'h3300_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_FLOAT32, 32'h3400_0000, 1'b1, 1'b0, '0, '0, '0, 1'b0);
        // pcm24 extremes; low byte dropped
        add_row(FMT_PCM24, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_PCM24, 32'h8000_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_PCM24, 32'h0000_00FF, 1'b1, 1'b0, '0, '0, '0, 1'b0);
        // unsupported format reports zeros
        add_row(FMT_UNSUP, 32'h1234_5678, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_UNSUP, 32'hFFFF_FFFF, 1'b1, 1'b1, '0, '0, '0, 1'b0);
        // format switched inside a buffer
        add_row(FMT_PCM16, 32'h0000_4000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_PCM24, 32'h4000_0000, 1'b1, 1'b0, '0, '0, '0, 1'b0);
        // unsupported close still clears the totals
        add_row(FMT_PCM16, 32'h0000_1000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_row(FMT_UNSUP, 32'h0000_0000, 1'b1, 1'b1, '0, '0, '0, 1'b0);
        add_row(FMT_PCM16, 32'h0000_0100, 1'b1, 1'b1, 63'(64'd1 << 32), 24'h01_0000, 17'd1,
                1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].fmt != fmt_q)
                set_sample_format(stim_rows[i].fmt);
            push_sample(stim_rows[i].word, stim_rows[i].last, stim_rows[i].typed,
                        stim_rows[i].res);
        end

        run_random_phase(0, 0, ITEMS_PER_PHASE);
        run_random_phase(60, 0, ITEMS_PER_PHASE);
        run_random_phase(0, 60, ITEMS_PER_PHASE);
        run_random_phase(38, 38, ITEMS_PER_PHASE);

        // Drain
        s_tvalid <= 1'b0;
        while (meter_reports_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d sample beats and checked %0d buffer totals across all four formats,",
                 beats_sent, reports_seen);
        $display("with float specials, pcm extremes and format switches under four idle mixes.");
        if (err_count == 0 && meter_reports_q.size() == 0)
            $display("audio_rms_peak_level_meter: match");
        else
            $display("audio_rms_peak_level_meter: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d totals still pending", meter_reports_q.size());
        $display("audio_rms_peak_level_meter: mismatch");
        $finish;
    end

endmodule

// File: files.f
sv/arpl_pkg.sv
sv/arpl_front.sv
sv/arpl_queue.sv
sv/arpl_back.sv
sv/audio_rms_peak_level_meter.sv
sim/audio_rms_peak_level_meter_tb.sv
